// ----- src/button_press_duration_classifier_top_defines.svh -----
// assertion macros for the button press duration classifier
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BPDC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPDC_ASSERT(lbl, prop, msg) `BPDC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define BPDC_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define BPDC_ASSERT(lbl, prop, msg)
`endif

`endif

// ----- src/bpdc_pkg.sv -----
// shared types and constants of the button press duration classifier
`default_nettype none

package bpdc_pkg;

  localparam int TIME_BITS_DEF = 16;
  localparam int MAX_EVT       = 4;
  localparam int CNT_W         = $clog2(MAX_EVT + 1);
  localparam int IDX_W         = $clog2(MAX_EVT);
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int MV_W          = 12;
  localparam int MS_W          = 16;

  localparam logic [MS_W-1:0] SHORT_MS_RST = MS_W'(50);
  localparam logic [MS_W-1:0] LONG_MS_RST  = MS_W'(1000);
  localparam logic [MS_W-1:0] HOLD_MS_RST  = MS_W'(3000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_ANALOG = 3'd0,
    REG_THRESH_MV  = 3'd1,
    REG_SHORT_MS   = 3'd2,
    REG_LONG_MS    = 3'd3,
    REG_HOLD_MS    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_SHORT = 2'd0,
    KIND_LONG  = 2'd1,
    KIND_HOLD  = 2'd2
  } click_kind_e;

  typedef struct packed {
    logic            use_analog;
    logic [MV_W-1:0] thresh_mv;
    logic [MS_W-1:0] short_ms;
    logic [MS_W-1:0] long_ms;
    logic [MS_W-1:0] hold_ms;
  } cfg_t;

  typedef struct packed {
    click_kind_e kind;
    logic        is_release;
  } evt_t;

  typedef struct packed {
    evt_t [MAX_EVT-1:0] list;
    logic [CNT_W-1:0]   cnt;
  } batch_t;

endpackage

`default_nettype wire

// ----- src/bpdc_cfg_regs.sv -----
// configuration register file of the button press duration classifier
`default_nettype none

module bpdc_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            we_i,
  input  wire logic [bpdc_pkg::CFG_IDX_W-1:0]  index_i,
  input  wire logic [bpdc_pkg::CFG_DATA_W-1:0] data_i,
  output bpdc_pkg::cfg_t                       cfg_o
);
  import bpdc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_reg_e'(index_i))
        REG_USE_ANALOG: cfg_d.use_analog = data_i[0];
        REG_THRESH_MV:  cfg_d.thresh_mv  = data_i[MV_W-1:0];
        REG_SHORT_MS:   cfg_d.short_ms   = data_i[MS_W-1:0];
        REG_LONG_MS:    cfg_d.long_ms    = data_i[MS_W-1:0];
        REG_HOLD_MS:    cfg_d.hold_ms    = data_i[MS_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_analog <= 1'b0;
      cfg_q.thresh_mv  <= '0;
      cfg_q.short_ms   <= SHORT_MS_RST;
      cfg_q.long_ms    <= LONG_MS_RST;
      cfg_q.hold_ms    <= HOLD_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- src/bpdc_core.sv -----
// press state machine, press timer and event list of one tick
`default_nettype none

module bpdc_core #(
  parameter int TIME_BITS = bpdc_pkg::TIME_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  bpdc_pkg::cfg_t                 cfg_i,
  input  wire logic                      fire_i,
  input  wire logic                      pin_level_i,
  input  wire logic [bpdc_pkg::MV_W-1:0] analog_mv_i,
  output bpdc_pkg::batch_t               batch_o
);
  import bpdc_pkg::*;

  localparam int CMP_W    = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;
  localparam int NUM_CAND = 6;

  typedef enum logic [3:0] {
    PH_STARTUP  = 4'b0001,
    PH_IDLE     = 4'b0010,
    PH_PRESSED  = 4'b0100,
    PH_HOLDWAIT = 4'b1000
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic                 short_sent_q, short_sent_d;
  logic                 long_sent_q, long_sent_d;

  logic                 pressed;
  logic [TIME_BITS-1:0] t_inc;
  logic [CMP_W-1:0]     cur_ext, nxt_ext, short_ext, long_ext, hold_ext;
  logic                 cur_ge_s, cur_ge_l, cur_ge_h;
  logic                 nxt_ge_s, nxt_ge_l, nxt_ge_h;
  logic [2:0]           rel_cur, rel_nxt;
  logic [NUM_CAND-1:0]  cand_v;
  evt_t                 cand [NUM_CAND];
  evt_t [MAX_EVT-1:0]   list_c;
  logic [CNT_W-1:0]     cnt_c;

  assign pressed = cfg_i.use_analog ? (analog_mv_i <= cfg_i.thresh_mv) : !pin_level_i;
  assign t_inc   = (time_q == {TIME_BITS{1'b1}}) ? time_q : time_q + 1'b1;

  assign cur_ext   = CMP_W'(time_q);
  assign nxt_ext   = CMP_W'(t_inc);
  assign short_ext = CMP_W'(cfg_i.short_ms);
  assign long_ext  = CMP_W'(cfg_i.long_ms);
  assign hold_ext  = CMP_W'(cfg_i.hold_ms);

  assign cur_ge_s = cur_ext >= short_ext;
  assign cur_ge_l = cur_ext >= long_ext;
  assign cur_ge_h = cur_ext >= hold_ext;
  assign nxt_ge_s = nxt_ext >= short_ext;
  assign nxt_ge_l = nxt_ext >= long_ext;
  assign nxt_ge_h = nxt_ext >= hold_ext;

  // release events: hold, long, short from high bit down
  assign rel_cur = {cur_ge_h, cur_ge_l & !cur_ge_h, cur_ge_s & !cur_ge_l};
  assign rel_nxt = {nxt_ge_h, nxt_ge_l & !nxt_ge_h, nxt_ge_s & !nxt_ge_l};

  always_comb begin
    cand[0] = '{kind: KIND_SHORT, is_release: 1'b0};
    cand[1] = '{kind: KIND_LONG,  is_release: 1'b0};
    cand[2] = '{kind: KIND_HOLD,  is_release: 1'b0};
    cand[3] = '{kind: KIND_SHORT, is_release: 1'b1};
    cand[4] = '{kind: KIND_LONG,  is_release: 1'b1};
    cand[5] = '{kind: KIND_HOLD,  is_release: 1'b1};
  end

  always_comb begin
    phase_d      = phase_q;
    time_d       = time_q;
    short_sent_d = short_sent_q;
    long_sent_d  = long_sent_q;
    cand_v       = '0;
    case (phase_q)
      PH_STARTUP, PH_HOLDWAIT: begin
        if (!pressed) phase_d = PH_IDLE;
      end
      PH_IDLE: begin
        if (pressed) begin
          time_d       = '0;
          short_sent_d = 1'b0;
          long_sent_d  = 1'b0;
          phase_d      = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (!pressed) begin
          cand_v[5:3] = rel_cur;
          phase_d     = PH_IDLE;
        end else begin
          time_d = t_inc;
          if (nxt_ge_s && !short_sent_q) begin
            short_sent_d = 1'b1;
            cand_v[0]    = 1'b1;
          end
          if (nxt_ge_l && !long_sent_q) begin
            long_sent_d = 1'b1;
            cand_v[1]   = 1'b1;
          end
          if (nxt_ge_h) begin
            cand_v[2]   = 1'b1;
            cand_v[5:3] = rel_nxt;
            phase_d     = PH_HOLDWAIT;
          end
        end
      end
      default: begin
        phase_d = PH_STARTUP;
      end
    endcase
  end

  // pack the raised events in order, at most MAX_EVT of them
  always_comb begin
    list_c = '0;
    cnt_c  = '0;
    for (int i = 0; i < NUM_CAND; i++) begin
      if (cand_v[i] && (cnt_c < CNT_W'(MAX_EVT))) begin
        list_c[cnt_c[IDX_W-1:0]] = cand[i];
        cnt_c = cnt_c + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_STARTUP;
      time_q       <= '0;
      short_sent_q <= 1'b0;
      long_sent_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      time_q       <= time_d;
      short_sent_q <= short_sent_d;
      long_sent_q  <= long_sent_d;
    end
  end

  assign batch_o.list = list_c;
  assign batch_o.cnt  = cnt_c;

endmodule

`default_nettype wire

// ----- src/bpdc_evt_queue.sv -----
// result register that hands out the events of one tick one at a time
`default_nettype none

module bpdc_evt_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  bpdc_pkg::batch_t batch_i,
  output logic            in_ready_o,
  output logic            valid_o,
  input  wire logic       ready_i,
  output bpdc_pkg::evt_t  evt_o,
  output logic            last_o
);
  import bpdc_pkg::*;

  evt_t [MAX_EVT-1:0] list_q, list_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               take;

  assign valid_o    = (cnt_q != '0);
  assign last_o     = (cnt_q == CNT_W'(1));
  assign evt_o      = list_q[0];
  assign take       = valid_o && ready_i;
  assign in_ready_o = !valid_o || (ready_i && last_o);

  always_comb begin
    list_d = list_q;
    cnt_d  = cnt_q;
    if (take) begin
      for (int i = 0; i < MAX_EVT - 1; i++) list_d[i] = list_q[i+1];
      cnt_d = cnt_q - 1'b1;
    end
    if (load_i && (batch_i.cnt != '0)) begin
      list_d = batch_i.list;
      cnt_d  = batch_i.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q <= list_d;
  end

endmodule

`default_nettype wire

// ----- src/button_press_duration_classifier_top.sv -----
// button press duration classifier: one input tick in, short/long/hold events out
//
// s_axis carries one 1 ms tick per transaction: pin level and analog millivolts.
// m_axis carries one event per transaction: click kind in tdata, release flag in
// tuser, tlast on the final event caused by a tick. A tick may cause no event.
// cfg writes one register per transaction, index 0..4; other indexes are ignored.
// cfg_ready_o is always high; write only while the block is idle.
// The events of a tick show on m_axis in the cycle after it is accepted.
// One tick per cycle is taken while each tick yields at most one event and the sink
// is ready; a tick with more events holds s_axis_tready_o low until its last event
// is taken, since the result register drains one event per cycle while the sink is ready.
// While m_axis_tready_i is low the pending events hold and s_axis_tready_o drops.
// Reset restores the register defaults, empties the result register and makes the
// block wait for a released tick before timing a press.
`default_nettype none
`include "button_press_duration_classifier_top_defines.svh"

module button_press_duration_classifier_top #(
  parameter int TIME_BITS = bpdc_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [15:0]                     s_axis_tdata_i,  // pin_level, analog_mv
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [7:0]                           m_axis_tdata_o,  // click_kind
  output logic                                 m_axis_tuser_o,  // event_kind
  output logic                                 m_axis_tlast_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bpdc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bpdc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bpdc_pkg::*;

  cfg_t   cfg;
  batch_t batch;
  evt_t   evt;
  logic   s_fire, m_fire;

  assign cfg_ready_o = 1'b1;
  assign s_fire      = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire      = m_axis_tvalid_o && m_axis_tready_i;

  bpdc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  bpdc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (s_fire),
    .pin_level_i (s_axis_tdata_i[0]),
    .analog_mv_i (s_axis_tdata_i[MV_W:1]),
    .batch_o     (batch)
  );

  bpdc_evt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s_fire),
    .batch_i    (batch),
    .in_ready_o (s_axis_tready_o),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .evt_o      (evt),
    .last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'b0, evt.kind};
  assign m_axis_tuser_o = evt.is_release;

  `BPDC_ASSERT(a_hold_press_not_last, m_fire && (m_axis_tdata_o[1:0] == KIND_HOLD) && !m_axis_tuser_o |-> !m_axis_tlast_o, "hold press ended a tick without its release")
  `BPDC_ASSERT(a_hold_release_last, m_fire && (m_axis_tdata_o[1:0] == KIND_HOLD) && m_axis_tuser_o |-> m_axis_tlast_o, "hold release was not the last event")
  `BPDC_ASSERT(a_events_shown, s_fire && (batch.cnt != '0) |=> m_axis_tvalid_o, "events of an accepted tick not presented")

endmodule

`default_nettype wire

// ----- bench/button_press_duration_classifier_top_test.sv -----
// self-checking bench: button ticks in, press and release events checked against a tracker
`timescale 1ns / 100ps

module button_press_duration_classifier_top_test;
  import bpdc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TICKS = 38;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef enum logic [1:0] {
    PH_WAIT_UP   = 2'd0,
    PH_IDLE      = 2'd1,
    PH_PRESSED   = 2'd2,
    PH_HOLD_WAIT = 2'd3
  } press_phase_e;

  typedef struct {
    click_kind_e kind;
    bit          is_release;
    bit          is_last;
  } due_event_t;

  class click_tracker;
    logic                     use_analog;
    logic [MV_W-1:0]          thr_mv;
    logic [MS_W-1:0]          short_ms;
    logic [MS_W-1:0]          long_ms;
    logic [MS_W-1:0]          hold_ms;
    press_phase_e             phase;
    logic [TIME_BITS_DEF-1:0] press_ms;
    bit                       short_sent;
    bit                       long_sent;
    due_event_t               due_events[$];
    due_event_t               tick_events[$];
    int                       mismatches;

    function new();
      use_analog = 1'b0;
      thr_mv = '0;
      short_ms = SHORT_MS_RST;
      long_ms = LONG_MS_RST;
      hold_ms = HOLD_MS_RST;
      phase = PH_WAIT_UP;
      press_ms = '0;
      short_sent = 1'b0;
      long_sent = 1'b0;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_USE_ANALOG: use_analog = val[0];
        REG_THRESH_MV:  thr_mv = val[MV_W-1:0];
        REG_SHORT_MS:   short_ms = val[MS_W-1:0];
        REG_LONG_MS:    long_ms = val[MS_W-1:0];
        REG_HOLD_MS:    hold_ms = val[MS_W-1:0];
        default: ;
      endcase
    endfunction

    function void add_event(click_kind_e kind, bit is_release);
      if (tick_events.size() < MAX_EVT) tick_events.push_back('{kind, is_release, 1'b0});
    endfunction

    function void add_releases();
      if (press_ms >= short_ms && press_ms < long_ms) add_event(KIND_SHORT, 1'b1);
      if (press_ms >= long_ms && press_ms < hold_ms) add_event(KIND_LONG, 1'b1);
      if (press_ms >= hold_ms) add_event(KIND_HOLD, 1'b1);
    endfunction

    function void take_tick(logic pin, logic [MV_W-1:0] mv);
      bit pressed;
      tick_events.delete();
      pressed = use_analog ? (mv <= thr_mv) : (pin == 1'b0);
      case (phase)
        PH_WAIT_UP, PH_HOLD_WAIT: begin
          if (!pressed) phase = PH_IDLE;
        end
        PH_IDLE: begin
          if (pressed) begin
            press_ms = '0;
            short_sent = 1'b0;
            long_sent = 1'b0;
            phase = PH_PRESSED;
          end
        end
        default: begin
          if (!pressed) begin
            add_releases();
            phase = PH_IDLE;
          end else begin
            if (press_ms != '1) press_ms++;
            if (press_ms >= short_ms && !short_sent) begin
              short_sent = 1'b1;
              add_event(KIND_SHORT, 1'b0);
            end
            if (press_ms >= long_ms && !long_sent) begin
              long_sent = 1'b1;
              add_event(KIND_LONG, 1'b0);
            end
            if (press_ms >= hold_ms) begin
              add_event(KIND_HOLD, 1'b0);
              add_releases();
              phase = PH_HOLD_WAIT;
            end
          end
        end
      endcase
      if (tick_events.size() > 0) tick_events[tick_events.size()-1].is_last = 1'b1;
      foreach (tick_events[i]) due_events.push_back(tick_events[i]);
    endfunction

    task check_event(logic [7:0] data, logic user, logic lst);
      due_event_t want;
      if (due_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event tdata %0h tuser %0b", data, user));
        return;
      end
      want = due_events.pop_front();
      if (data !== {6'b0, want.kind})
        report_mismatch($sformatf("click kind %0h, expected %0h", data, want.kind));
      if (user !== want.is_release)
        report_mismatch($sformatf("event kind %0b, expected %0b", user, want.is_release));
      if (lst !== want.is_last)
        report_mismatch($sformatf("tlast %0b, expected %0b", lst, want.is_last));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [15:0]           s_axis_tdata_i;  // pin_level, analog_mv
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [7:0]            m_axis_tdata_o;  // click_kind
  logic                  m_axis_tuser_o;  // event_kind
  logic                  m_axis_tlast_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  click_tracker board = new();
  int  cycles = 0;
  int  ticks_sent = 0;
  int  send_idle_pct = 0;
  int  sink_stall_pct = 0;
  bit  hold_off_req = 1'b0;
  int  hold_off_left = 0;

  button_press_duration_classifier_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_off_left = HOLD_OFF_CYCLES;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      board.check_event(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
  end

  // entered and left at a falling edge; tvalid stays high for the next tick
  task automatic send_tick(input logic pin, input logic [MV_W-1:0] mv);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {3'b0, mv, pin};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.take_tick(pin, mv);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_level(input bit want_pressed, input int count);
    logic            pin;
    logic [MV_W-1:0] mv;
    repeat (count) begin
      pin = 1'($urandom_range(1));
      mv = MV_W'($urandom_range(4095));
      if (!board.use_analog) pin = !want_pressed;
      else if (want_pressed) mv = MV_W'($urandom_range(board.thr_mv));
      else if (board.thr_mv != '1) mv = MV_W'($urandom_range(4095, board.thr_mv + 1));
      send_tick(pin, mv);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input bit lower);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, val);
    @(negedge clk_i);
    if (lower) cfg_valid_i <= 1'b0;
  endtask

  // waits until every expected event is out, then lets the block settle
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (board.due_events.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic configure(input logic [15:0] analog, input logic [15:0] thr,
                           input logic [15:0] s_ms, input logic [15:0] l_ms,
                           input logic [15:0] h_ms);
    drain();
    write_reg(REG_USE_ANALOG, analog, 1'b0);
    write_reg(REG_THRESH_MV, thr, 1'b0);
    write_reg(REG_SHORT_MS, s_ms, 1'b0);
    write_reg(REG_LONG_MS, l_ms, 1'b0);
    write_reg(REG_HOLD_MS, h_ms, 1'b1);
  endtask

  initial begin
    int goal;
    int span;
    logic [15:0] s_ms;
    logic [15:0] l_ms;
    logic [15:0] h_ms;

    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // defaults: startup wait, then a press too short for any event
    send_tick(1'b0, 12'h000);
    send_tick(1'b0, 12'hFFF);
    send_tick(1'b1, 12'hFFF);
    send_tick(1'b0, 12'h000);
    send_tick(1'b1, 12'h000);

    // analog, top threshold with stray upper bits, zero thresholds: four events
    configure(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    send_tick(1'b1, 12'hFFF);
    send_tick(1'b0, 12'h800);

    // digital by masked write, release right after a single pressed tick with zero thresholds
    configure(16'hFFFE, 16'hF000, 16'd0, 16'd0, 16'd0);
    send_tick(1'b1, 12'h000);
    send_tick(1'b0, 12'hABC);
    send_tick(1'b1, 12'h555);

    // unused register indexes, then unordered thresholds
    drain();
    write_reg(REG_UNUSED_LO, 16'hFFFF, 1'b0);
    write_reg(REG_UNUSED_HI, 16'h0001, 1'b1);
    configure(16'd1, 16'd100, 16'd1, 16'd5, 16'd1);
    send_tick(1'b0, 12'd200);
    send_tick(1'b1, 12'd100);
    send_tick(1'b0, 12'd0);
    send_tick(1'b0, 12'd101);

    // long before short, hold at maximum, long release
    configure(16'd0, 16'd0, 16'd2, 16'd1, 16'hFFFF);
    send_tick(1'b0, 12'h123);
    send_tick(1'b0, 12'h456);
    send_tick(1'b0, 12'h789);
    send_tick(1'b1, 12'hFED);

    // all thresholds at maximum, zero analog threshold
    configure(16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(1'b1, 12'd0);
    send_tick(1'b0, 12'd1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 6) begin
        s_ms = 16'($urandom_range(20));
        l_ms = 16'($urandom_range(20));
        h_ms = 16'($urandom_range(20));
      end else begin
        s_ms = 16'($urandom_range(6));
        l_ms = s_ms + 16'($urandom_range(8));
        h_ms = l_ms + 16'($urandom_range(1, 10));
      end
      configure(16'($urandom_range(1)), 16'($urandom_range(1, 4094)), s_ms, l_ms, h_ms);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 69;
          sink_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          sink_stall_pct = 69;
        end
        default: begin
          send_idle_pct = 26;
          sink_stall_pct = 26;
        end
      endcase
      if (p == 0) hold_off_req = 1'b1;
      span = (board.hold_ms + 4 > 30) ? 30 : board.hold_ms + 4;
      goal = ticks_sent + PHASE_TICKS;
      while (ticks_sent < goal) begin
        if ($urandom_range(9) < 8) begin
          send_level(1'b1, $urandom_range(1, span));
          send_level(1'b0, $urandom_range(1, 3));
        end else begin
          repeat ($urandom_range(1, 4))
            send_tick(1'($urandom_range(1)), MV_W'($urandom_range(4095)));
        end
      end
    end

    drain();
    repeat (10) @(negedge clk_i);
    if (board.due_events.size() != 0)
      board.report_mismatch($sformatf("%0d events never arrived", board.due_events.size()));
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- button_press_duration_classifier_top.f -----
+incdir+src
src/bpdc_pkg.sv
src/bpdc_cfg_regs.sv
src/bpdc_core.sv
src/bpdc_evt_queue.sv
src/button_press_duration_classifier_top.sv
bench/button_press_duration_classifier_top_test.sv
